@@ rtl/ladsr_pkg.sv @@
// Shared constants for the linear ADSR envelope: operation, stage, velocity and register codes and reset values.
`default_nettype none

package ladsr_pkg;

	// Default number of fraction bits of the level; full scale is 2**LEVEL_FRAC_BITS.
	localparam int unsigned LEVEL_FRAC_BITS_DEF = 24;

	// Operation codes of an input beat.
	localparam int unsigned OP_W = 2;
	localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

	// Envelope stage codes.
	localparam int unsigned STAGE_W = 3;
	localparam logic [STAGE_W-1:0] STAGE_IDLE    = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
	localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
	localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;

	// Velocity width and the divisor that scales velocity to unity.
	localparam int unsigned VEL_W   = 7;
	localparam int unsigned VEL_MAX = 127;
	localparam logic [VEL_W-1:0] VEL_RESET = 7'd127;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 2'd3;

	// Reset values of the step registers.
	localparam int unsigned STEP_RESET = 35;

endpackage : ladsr_pkg

`default_nettype wire

@@ rtl/linear_adsr_envelope.sv @@
// Linear ADSR envelope generator: stage machine, level update and velocity scaling.
// A sample tick's result passes registers s1, s2, s3 and the output register.
// One beat per cycle unless out_ready stalls; note-on/off beats give no result.
// The state update is one add or subtract with a compare; the velocity scaling runs
// through a product register and a reciprocal-multiply register before the output.
// Reset (arst_n low) clears the level to zero, enters idle, sets the held velocity
// to 127 and loads the step and sustain registers with their default values.
`default_nettype none

module linear_adsr_envelope
	import ladsr_pkg::*;
#(
	parameter int unsigned LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	// Configuration write port.
	input  wire logic                       cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [LEVEL_FRAC_BITS:0]   cfg_data,

	// Input channel.
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [OP_W-1:0]            operation,
	input  wire logic [VEL_W-1:0]           note_velocity,

	// Result channel.
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [LEVEL_FRAC_BITS:0]        envelope_out,
	output logic [STAGE_W-1:0]              current_stage
);

	// Level width: one integer bit above the fraction so that full scale fits.
	localparam int unsigned LW = LEVEL_FRAC_BITS + 1;
	// Width of level times velocity.
	localparam int unsigned PW = LW + VEL_W;
	// Quotient width after dividing the product by 127.
	localparam int unsigned QW = PW - 6;
	// Reciprocal of 127 scaled by 2**(PW+7); the truncation leaves the estimate
	// at most one below the true quotient, which the last stage corrects.
	localparam logic [PW:0] RECIP = (PW+1)'((64'd1 << (PW + 7)) / 64'(VEL_MAX));
	localparam logic [LW-1:0] FULL = LW'(1) << LEVEL_FRAC_BITS;
	localparam logic [PW-1:0] DIVISOR = PW'(VEL_MAX);

	// Configuration registers.
	logic [LW-1:0] attack_step_q;
	logic [LW-1:0] decay_step_q;
	logic [LW-1:0] sustain_level_q;
	logic [LW-1:0] release_step_q;

	// Envelope state.
	logic [LW-1:0]      level_q;
	logic [STAGE_W-1:0] stage_q;
	logic [VEL_W-1:0]   held_vel_q;

	// Pipeline registers of the result path.
	logic               vld_s1, vld_s2, vld_s3, out_vld_q;
	logic [LW-1:0]      level_s1;
	logic [VEL_W-1:0]   vel_s1;
	logic [STAGE_W-1:0] stage_s1, stage_s2, stage_s3, stage_out_q;
	logic [PW-1:0]      prod_s2;
	logic [PW-1:0]      prod_s3;
	logic [QW-1:0]      quot_s3;
	logic [LW-1:0]      env_out_q;

	// Handshake and enables. Each stage moves when its successor has room, so a
	// bubble anywhere in the chain lets the input keep flowing behind a stalled result.
	logic in_fire;
	logic en_out, en_s3, en_s2, en_s1;

	assign en_out   = !out_vld_q || out_ready;
	assign en_s3    = !vld_s3 || en_out;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_fire  = in_valid && in_ready;

	logic is_tick;
	assign is_tick = in_fire && (operation == OP_TICK);

	// The sustain level read from its register saturates at full scale.
	logic [LW-1:0] sus_level;
	assign sus_level = (sustain_level_q > FULL) ? FULL : sustain_level_q;

	// One tick of the envelope: the next level and stage from the current ones.
	logic [LW:0]        attack_sum;
	logic [LW-1:0]      decay_gap;
	logic [LW-1:0]      tick_level;
	logic [STAGE_W-1:0] tick_stage;

	assign attack_sum = {1'b0, level_q} + {1'b0, attack_step_q};
	assign decay_gap  = level_q - sus_level;

	always_comb begin
		tick_level = level_q;
		tick_stage = stage_q;
		case (stage_q)
			STAGE_ATTACK: begin
				if (attack_sum >= {1'b0, FULL}) begin
					tick_level = FULL;
					tick_stage = STAGE_DECAY;
				end else begin
					tick_level = attack_sum[LW-1:0];
				end
			end
			STAGE_DECAY: begin
				// The gap is only meaningful when the level sits above sustain.
				if (level_q <= sus_level || decay_gap <= decay_step_q) begin
					tick_level = sus_level;
					tick_stage = STAGE_SUSTAIN;
				end else begin
					tick_level = level_q - decay_step_q;
				end
			end
			STAGE_SUSTAIN: begin
				tick_level = sus_level;
			end
			STAGE_RELEASE: begin
				if (level_q <= release_step_q) begin
					tick_level = '0;
					tick_stage = STAGE_IDLE;
				end else begin
					tick_level = level_q - release_step_q;
				end
			end
			default: begin
				tick_level = '0;
				tick_stage = STAGE_IDLE;
			end
		endcase
	end

	// Configuration writes; indexes outside the list leave everything unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_step_q   <= LW'(STEP_RESET);
			decay_step_q    <= LW'(STEP_RESET);
			sustain_level_q <= FULL;
			release_step_q  <= LW'(STEP_RESET);
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_ATTACK_STEP:   attack_step_q   <= cfg_data;
				REG_DECAY_STEP:    decay_step_q    <= cfg_data;
				REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data;
				REG_RELEASE_STEP:  release_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Envelope state. Note-on keeps the current level and restarts attack from it;
	// note-off jumps to release from whatever stage is active.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			stage_q    <= STAGE_IDLE;
			held_vel_q <= VEL_RESET;
		end else if (in_fire) begin
			case (operation)
				OP_TICK: begin
					level_q <= tick_level;
					stage_q <= tick_stage;
				end
				OP_NOTE_ON: begin
					held_vel_q <= note_velocity;
					stage_q    <= STAGE_ATTACK;
				end
				OP_NOTE_OFF: begin
					stage_q <= STAGE_RELEASE;
				end
				default: ;
			endcase
		end
	end

	// Valid bits of the result path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= is_tick;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_out) out_vld_q <= vld_s3;
		end
	end

	// Divide-by-127 datapath. Stage 3 holds a reciprocal estimate that may be one
	// short; the remainder x - 127*q is below 254, so N-bit wraparound is harmless
	// and one compare decides the final increment.
	logic [2*PW:0] recip_prod;
	logic [QW-1:0] quot_est;
	logic [PW-1:0] remainder;
	logic [QW-1:0] quot_final;

	assign recip_prod = (2*PW+1)'(prod_s2) * (2*PW+1)'(RECIP);
	assign quot_est   = recip_prod[2*PW -: QW];
	assign remainder  = prod_s3 - PW'({quot_s3, 7'b0}) + PW'(quot_s3);
	assign quot_final = quot_s3 + QW'(remainder >= DIVISOR);

	// Payload registers of the result path.
	always_ff @(posedge clk) begin
		if (en_s1 && is_tick) begin
			level_s1 <= tick_level;
			vel_s1   <= held_vel_q;
			stage_s1 <= tick_stage;
		end
		if (en_s2 && vld_s1) begin
			prod_s2  <= PW'(level_s1) * PW'(vel_s1);
			stage_s2 <= stage_s1;
		end
		if (en_s3 && vld_s2) begin
			prod_s3  <= prod_s2;
			quot_s3  <= quot_est;
			stage_s3 <= stage_s2;
		end
		if (en_out && vld_s3) begin
			env_out_q   <= LW'(quot_final);
			stage_out_q <= stage_s3;
		end
	end

	assign out_valid     = out_vld_q;
	assign envelope_out  = env_out_q;
	assign current_stage = stage_out_q;

`ifndef SYNTH
	// The level never leaves the range from zero to full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= FULL)
		else $error("envelope level above full scale");

	// An idle envelope always sits at zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == STAGE_IDLE) |-> (level_q == '0))
		else $error("idle stage with nonzero level");

	// Every accepted tick enters the result path on the next edge.
	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> vld_s1)
		else $error("accepted tick did not enter the result path");

	// Note beats never create a result.
	a_note_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (operation != OP_TICK)) |=> !vld_s1)
		else $error("note beat produced a result");

	// Scaled output never exceeds full scale.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (env_out_q <= FULL))
		else $error("scaled envelope above full scale");
`endif

endmodule : linear_adsr_envelope

`default_nettype wire
